/* hdl/gce_pkg.sv */
// Shared constants, types and register codes of the glyph color expander.
`default_nettype none
package gce_pkg;

	localparam int unsigned CHAR_COUNT  = 256;
	localparam int unsigned MAX_ROWS    = 32;
	localparam int unsigned MAX_WIDTH   = 32;

	localparam int unsigned CODE_W      = $clog2(CHAR_COUNT);
	localparam int unsigned ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned STORE_DEPTH = CHAR_COUNT * MAX_ROWS;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
	localparam int unsigned ROWS_CAP    = (MAX_ROWS < 32) ? MAX_ROWS : 32;
	localparam int unsigned WIDTH_CAP   = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

	localparam int unsigned WIDTH_REG_W = 6;
	localparam int unsigned HEIGHT_REG_W = 6;
	localparam int unsigned PITCH_REG_W = 13;
	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned RIDX_W  = 5;
	localparam int unsigned BITS_W  = 32;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned COLOR_W = 32;
	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned MASK_W  = 32;

	localparam int unsigned S_TDATA_W = 104;
	localparam int unsigned M_TDATA_W = 88;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH  = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef struct packed {
		logic [WIDTH_REG_W-1:0]  cell_width;
		logic [HEIGHT_REG_W-1:0] cell_height;
		logic [PITCH_REG_W-1:0]  line_pitch;
	} cfg_t;

	typedef struct packed {
		logic               last_row;
		logic [COLOR_W-1:0] color_out;
		logic [MASK_W-1:0]  pixel_mask;
		logic [ADDR_W-1:0]  pixel_address;
	} span_t;

endpackage
`default_nettype wire

/* hdl/gce_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gce_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* hdl/gce_cfg.sv */
// Configuration register file of the glyph color expander.
`default_nettype none
module gce_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [gce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output gce_pkg::cfg_t                         cfg
);

	gce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_width  <= gce_pkg::WIDTH_REG_W'(8);
			cfg_q.cell_height <= gce_pkg::HEIGHT_REG_W'(16);
			cfg_q.line_pitch  <= gce_pkg::PITCH_REG_W'(1024);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				gce_pkg::REG_CELL_WIDTH: begin
					cfg_q.cell_width <= cfg_wdata[gce_pkg::WIDTH_REG_W-1:0];
				end
				gce_pkg::REG_CELL_HEIGHT: begin
					cfg_q.cell_height <= cfg_wdata[gce_pkg::HEIGHT_REG_W-1:0];
				end
				gce_pkg::REG_LINE_PITCH: begin
					cfg_q.line_pitch <= cfg_wdata[gce_pkg::PITCH_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hdl/gce_seq.sv */
// Request sequencer: glyph row loads, row read issue and span output queue.
`default_nettype none
module gce_seq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire gce_pkg::cfg_t                     cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              in_req_type,
	input  wire logic [gce_pkg::CHAR_W-1:0]        in_char_code,
	input  wire logic [gce_pkg::RIDX_W-1:0]        in_row_index,
	input  wire logic [gce_pkg::BITS_W-1:0]        in_row_bits,
	input  wire logic [gce_pkg::POS_W-1:0]         in_x_pos,
	input  wire logic [gce_pkg::POS_W-1:0]         in_y_pos,
	input  wire logic [gce_pkg::COLOR_W-1:0]       in_color,
	output logic                                   ram_wr_en,
	output logic [gce_pkg::STORE_AW-1:0]           ram_wr_addr,
	output logic [gce_pkg::BITS_W-1:0]             ram_wr_data,
	output logic                                   ram_rd_en,
	output logic [gce_pkg::STORE_AW-1:0]           ram_rd_addr,
	input  wire logic [gce_pkg::BITS_W-1:0]        ram_rd_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output gce_pkg::span_t                         out_span
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DRAW = 2'b10
	} state_t;

	localparam int unsigned RCNT_W = $clog2(gce_pkg::ROWS_CAP + 1);

	state_t                             state_q;
	logic [gce_pkg::CODE_W-1:0]         code_q;
	logic [gce_pkg::ROW_W-1:0]          row_q;
	logic [RCNT_W-1:0]                  rows_q;
	logic [gce_pkg::MASK_W-1:0]         wmask_q;
	logic [gce_pkg::COLOR_W-1:0]        color_q;
	logic [gce_pkg::ADDR_W-1:0]         addr_q;
	logic                               v_s1;
	logic [gce_pkg::ADDR_W-1:0]         addr_s1;
	logic                               last_s1;
	gce_pkg::span_t                     e0_q;
	gce_pkg::span_t                     e1_q;
	logic [1:0]                         cnt_q;

	logic                               accept;
	logic                               issue;
	logic                               last_issue;
	logic                               pop;
	logic [RCNT_W-1:0]                  rows_d;
	logic [gce_pkg::WIDTH_REG_W-1:0]    width_d;
	logic [gce_pkg::MASK_W-1:0]         wmask_d;
	logic [gce_pkg::POS_W+gce_pkg::PITCH_REG_W-1:0] prod;
	logic [gce_pkg::ADDR_W-1:0]         base_d;
	logic [gce_pkg::BITS_W-1:0]         rev_bits;
	gce_pkg::span_t                     push_span;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	always_comb begin
		if (cfg.cell_height == '0) begin
			rows_d = RCNT_W'(1);
		end else if (32'(cfg.cell_height) > gce_pkg::ROWS_CAP) begin
			rows_d = RCNT_W'(gce_pkg::ROWS_CAP);
		end else begin
			rows_d = RCNT_W'(cfg.cell_height);
		end
		if (cfg.cell_width == '0) begin
			width_d = gce_pkg::WIDTH_REG_W'(1);
		end else if (32'(cfg.cell_width) > gce_pkg::WIDTH_CAP) begin
			width_d = gce_pkg::WIDTH_REG_W'(gce_pkg::WIDTH_CAP);
		end else begin
			width_d = cfg.cell_width;
		end
		wmask_d = ~({gce_pkg::MASK_W{1'b1}} << width_d);
		prod    = {{gce_pkg::PITCH_REG_W{1'b0}}, in_y_pos}
			* {{gce_pkg::POS_W{1'b0}}, cfg.line_pitch};
		base_d  = prod[gce_pkg::ADDR_W-1:0]
			+ {{(gce_pkg::ADDR_W-gce_pkg::POS_W){1'b0}}, in_x_pos};
	end

	assign ram_wr_en   = accept && (in_req_type == gce_pkg::REQ_LOAD)
		&& (32'(in_row_index) < gce_pkg::MAX_ROWS);
	assign ram_wr_addr = {in_char_code[gce_pkg::CODE_W-1:0], in_row_index[gce_pkg::ROW_W-1:0]};
	assign ram_wr_data = in_row_bits;

	assign issue = (state_q == ST_DRAW)
		&& (({1'b0, cnt_q} + 3'(v_s1)) <= (3'd1 + 3'(pop)));
	assign last_issue  = ((RCNT_W'(row_q) + RCNT_W'(1)) == rows_q);
	assign ram_rd_en   = issue;
	assign ram_rd_addr = {code_q, row_q};

	always_comb begin
		for (int i = 0; i < gce_pkg::BITS_W; i++) begin
			rev_bits[i] = ram_rd_data[gce_pkg::BITS_W-1-i];
		end
		push_span.last_row      = last_s1;
		push_span.color_out     = color_q;
		push_span.pixel_mask    = rev_bits & wmask_q;
		push_span.pixel_address = addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			v_s1    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					if (accept && (in_req_type == gce_pkg::REQ_DRAW)) begin
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (issue) begin
						row_q <= row_q + gce_pkg::ROW_W'(1);
						if (last_issue) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			cnt_q <= cnt_q + 2'(v_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_req_type == gce_pkg::REQ_DRAW)) begin
			code_q  <= in_char_code[gce_pkg::CODE_W-1:0];
			rows_q  <= rows_d;
			wmask_q <= wmask_d;
			color_q <= in_color;
			addr_q  <= base_d;
		end else if (issue) begin
			addr_q <= addr_q
				+ {{(gce_pkg::ADDR_W-gce_pkg::PITCH_REG_W){1'b0}}, cfg.line_pitch};
		end
		if (issue) begin
			addr_s1 <= addr_q;
			last_s1 <= last_issue;
		end
		if ((v_s1 && (cnt_q == 2'd0)) || (v_s1 && pop && (cnt_q == 2'd1))) begin
			e0_q <= push_span;
		end else if (pop && (cnt_q == 2'd2)) begin
			e0_q <= e1_q;
		end
		if (v_s1 && (((cnt_q == 2'd1) && !pop) || ((cnt_q == 2'd2) && pop))) begin
			e1_q <= push_span;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_span  = e0_q;

endmodule
`default_nettype wire

/* hdl/glyph_color_expander_top.sv */
// Top level of the glyph color expander: stream ports, config, store and sequencer.
//
// The block keeps one 32-bit word per glyph row in an 8192-entry glyph memory
// (256 characters of 32 rows). A load transaction (tuser 0) writes one row.
// A draw transaction (tuser 1) is taken in, then the sequencer reads one glyph
// row per cycle through the single read port of the glyph memory while the
// output side keeps up, and emits one span per row; the input side is not
// ready until the last row read of a draw has issued. A stalled output holds
// the reads back through a two-entry span queue. Rows of the store that were
// never loaded read as arbitrary data. No clearing pass runs after reset.
`default_nettype none
module glyph_color_expander_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [gce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// char_code[7:0], row_index[12:8], row_bits[44:13], x_pos[56:45],
	// y_pos[68:57], color[100:69], zero pad[103:101]
	input  wire logic [gce_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type[0]
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// pixel_address[23:0], pixel_mask[55:24], color_out[87:56]
	output logic [gce_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic                                  m_tlast
);

	gce_pkg::cfg_t                   cfg;
	gce_pkg::span_t                  span;
	logic                            ram_wr_en;
	logic [gce_pkg::STORE_AW-1:0]    ram_wr_addr;
	logic [gce_pkg::BITS_W-1:0]      ram_wr_data;
	logic                            ram_rd_en;
	logic [gce_pkg::STORE_AW-1:0]    ram_rd_addr;
	logic [gce_pkg::BITS_W-1:0]      ram_rd_data;

	gce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gce_ram #(
		.WIDTH (gce_pkg::BITS_W),
		.DEPTH (gce_pkg::STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	gce_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_req_type  (s_tuser),
		.in_char_code (s_tdata[7:0]),
		.in_row_index (s_tdata[12:8]),
		.in_row_bits  (s_tdata[44:13]),
		.in_x_pos     (s_tdata[56:45]),
		.in_y_pos     (s_tdata[68:57]),
		.in_color     (s_tdata[100:69]),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr),
		.ram_rd_data  (ram_rd_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_span     (span)
	);

	assign m_tdata = {span.color_out, span.pixel_mask, span.pixel_address};
	assign m_tlast = span.last_row;

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the glyph color expander: glyph loads, draws and span checking.
module tb;

	localparam logic [gce_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [gce_pkg::CHAR_W-1:0] GLYPH_A = 8'h41;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [gce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gce_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// char_code, row_index, row_bits, x_pos, y_pos, color, zero pad (from bit 0)
	logic [gce_pkg::S_TDATA_W-1:0] s_tdata = '0;
	// req_type
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// pixel_address, pixel_mask, color_out (from bit 0)
	logic [gce_pkg::M_TDATA_W-1:0] m_tdata;
	logic m_tlast;

	logic [gce_pkg::BITS_W-1:0] font_rows [gce_pkg::CHAR_COUNT][gce_pkg::MAX_ROWS];
	bit row_loaded [gce_pkg::CHAR_COUNT][gce_pkg::MAX_ROWS];
	logic [gce_pkg::WIDTH_REG_W-1:0] cfg_width = 6'd8;
	logic [gce_pkg::HEIGHT_REG_W-1:0] cfg_height = 6'd16;
	logic [gce_pkg::PITCH_REG_W-1:0] cfg_pitch = 13'd1024;
	gce_pkg::span_t span_queue[$];
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	bit steady = 1'b0;

	glyph_color_expander_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("glyph_color_expander_top verification failed");
		$finish;
	end

	always @(posedge clk) begin : check_span
		gce_pkg::span_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (span_queue.size() == 0) begin
				mismatches++;
				$error("unexpected span: pixel_address %h", m_tdata[23:0]);
			end else begin
				want = span_queue.pop_front();
				if (m_tdata[23:0] !== want.pixel_address) begin
					mismatches++;
					$error("pixel_address: expected %h, actual %h",
						want.pixel_address, m_tdata[23:0]);
				end
				if (m_tdata[55:24] !== want.pixel_mask) begin
					mismatches++;
					$error("pixel_mask: expected %h, actual %h",
						want.pixel_mask, m_tdata[55:24]);
				end
				if (m_tdata[87:56] !== want.color_out) begin
					mismatches++;
					$error("color_out: expected %h, actual %h",
						want.color_out, m_tdata[87:56]);
				end
				if (m_tlast !== want.last_row) begin
					mismatches++;
					$error("last_row: expected %b, actual %b", want.last_row, m_tlast);
				end
			end
		end
	end

	function automatic int unsigned active_rows();
		int unsigned h;
		h = cfg_height;
		if (h == 0) h = 1;
		if (h > gce_pkg::ROWS_CAP) h = gce_pkg::ROWS_CAP;
		return h;
	endfunction

	function automatic logic [gce_pkg::MASK_W-1:0] width_mask();
		int unsigned w;
		w = cfg_width;
		if (w == 0) w = 1;
		if (w > gce_pkg::WIDTH_CAP) w = gce_pkg::WIDTH_CAP;
		return (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
	endfunction

	function automatic bit glyph_ready(input logic [gce_pkg::CHAR_W-1:0] code);
		int unsigned rows;
		rows = active_rows();
		for (int unsigned r = 0; r < rows; r++) begin
			if (!row_loaded[code][r]) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic render_request(input logic req, input logic [gce_pkg::CHAR_W-1:0] code,
		input logic [gce_pkg::RIDX_W-1:0] ridx, input logic [gce_pkg::BITS_W-1:0] bits,
		input logic [gce_pkg::POS_W-1:0] x, input logic [gce_pkg::POS_W-1:0] y,
		input logic [gce_pkg::COLOR_W-1:0] color);
		int unsigned rows;
		logic [gce_pkg::MASK_W-1:0] wmask;
		logic [gce_pkg::MASK_W-1:0] flipped;
		logic [31:0] line;
		gce_pkg::span_t s;
		if (req == gce_pkg::REQ_LOAD) begin
			if (ridx < gce_pkg::MAX_ROWS) begin
				font_rows[code][ridx] = bits;
				row_loaded[code][ridx] = 1'b1;
			end
			return;
		end
		rows = active_rows();
		wmask = width_mask();
		for (int unsigned r = 0; r < rows; r++) begin
			line = (32'(y) + r) * 32'(cfg_pitch) + 32'(x);
			for (int b = 0; b < 32; b++) flipped[b] = font_rows[code][r][31 - b];
			s.pixel_address = line[gce_pkg::ADDR_W-1:0];
			s.pixel_mask = flipped & wmask;
			s.color_out = color;
			s.last_row = (r + 1 == rows);
			span_queue.push_back(s);
		end
	endtask

	task automatic send_item(input logic req, input logic [gce_pkg::CHAR_W-1:0] code,
		input logic [gce_pkg::RIDX_W-1:0] ridx, input logic [gce_pkg::BITS_W-1:0] bits,
		input logic [gce_pkg::POS_W-1:0] x, input logic [gce_pkg::POS_W-1:0] y,
		input logic [gce_pkg::COLOR_W-1:0] color);
		while (!steady && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b000, color, y, x, bits, ridx, code};
		do @(posedge clk); while (!s_tready);
		render_request(req, code, ridx, bits, x, y, color);
	endtask

	// Drop valid, wait out every span, then let the last draw finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (span_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [gce_pkg::CFG_DATA_W-1:0] w,
		input logic [gce_pkg::CFG_DATA_W-1:0] h, input logic [gce_pkg::CFG_DATA_W-1:0] p);
		cfg_wen <= 1'b1;
		cfg_index <= gce_pkg::REG_CELL_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= gce_pkg::REG_CELL_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= gce_pkg::REG_LINE_PITCH;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= 13'($urandom_range(8191));
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_width = w[gce_pkg::WIDTH_REG_W-1:0];
		cfg_height = h[gce_pkg::HEIGHT_REG_W-1:0];
		cfg_pitch = p[gce_pkg::PITCH_REG_W-1:0];
	endtask

	task automatic test_reset_defaults();
		logic [gce_pkg::BITS_W-1:0] bits;
		for (int r = 0; r < gce_pkg::MAX_ROWS; r++) begin
			case (r)
				0: begin
					bits = 32'h8000_0001;
				end
				1: begin
					bits = 32'hFFFF_FFFF;
				end
				2: begin
					bits = 32'h0000_0000;
				end
				3: begin
					bits = 32'hAAAA_5555;
				end
				default: begin
					bits = $urandom;
				end
			endcase
			send_item(gce_pkg::REQ_LOAD, GLYPH_A, r[gce_pkg::RIDX_W-1:0], bits,
				12'($urandom_range(4095)), 12'($urandom_range(4095)), $urandom);
		end
		send_item(gce_pkg::REQ_DRAW, GLYPH_A, '0, '0, 12'd0, 12'd0, 32'h0000_0000);
		send_item(gce_pkg::REQ_DRAW, GLYPH_A, '1, '1, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
	endtask

	task automatic test_config_extremes();
		send_item(gce_pkg::REQ_LOAD, 8'h00, 5'd0, $urandom, 12'd0, 12'd0, $urandom);
		send_item(gce_pkg::REQ_LOAD, 8'hFF, 5'd0, $urandom, 12'd4095, 12'd4095, $urandom);
		settle();
		// zero width and height with junk above the register bits, zero pitch
		set_config(13'h1FC0, 13'h0040, 13'd0);
		send_item(gce_pkg::REQ_DRAW, 8'h00, 5'd31, $urandom, 12'd4095, 12'd0, $urandom);
		send_item(gce_pkg::REQ_DRAW, 8'hFF, 5'd0, $urandom, 12'd0, 12'd4095, $urandom);
		settle();
		set_config(13'd63, 13'd63, 13'd8191);
		send_item(gce_pkg::REQ_DRAW, GLYPH_A, 5'd0, $urandom, 12'd4095, 12'd4095, $urandom);
		settle();
		set_config(13'd32, 13'd32, 13'd4096);
		send_item(gce_pkg::REQ_DRAW, GLYPH_A, 5'd0, $urandom, 12'd0, 12'd0, $urandom);
		settle();
		set_config(13'd1, 13'd1, 13'd1);
		send_item(gce_pkg::REQ_DRAW, 8'hFF, 5'd0, $urandom, 12'd4095, 12'd4095, $urandom);
	endtask

	task automatic test_random_traffic();
		logic [gce_pkg::CHAR_W-1:0] build_code;
		int unsigned build_row;
		logic [gce_pkg::CHAR_W-1:0] ready[$];
		int unsigned pick;
		build_code = 8'($urandom_range(255));
		build_row = 0;
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			if (phase == 0) begin
				set_config(13'd8, 13'd16, 13'd1024);
			end else if (phase == 2) begin
				set_config(13'($urandom_range(8191)), 13'($urandom_range(1, 8)),
					13'($urandom_range(8191)));
			end else begin
				set_config(13'($urandom_range(8191)), 13'($urandom_range(8191)),
					13'($urandom_range(8191)));
			end
			steady = (phase == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				ready.delete();
				for (int c = 0; c < gce_pkg::CHAR_COUNT; c++) begin
					if (glyph_ready(c[gce_pkg::CHAR_W-1:0])) begin
						ready.push_back(c[gce_pkg::CHAR_W-1:0]);
					end
				end
				if (pick < 45 && ready.size() > 0) begin
					send_item(gce_pkg::REQ_DRAW, ready[$urandom_range(ready.size() - 1)],
						5'($urandom_range(31)), $urandom, 12'($urandom_range(4095)),
						12'($urandom_range(4095)), $urandom);
				end else if (pick < 85) begin
					// fill one glyph row by row so it becomes drawable at any height
					send_item(gce_pkg::REQ_LOAD, build_code,
						build_row[gce_pkg::RIDX_W-1:0], $urandom,
						12'($urandom_range(4095)), 12'($urandom_range(4095)), $urandom);
					build_row++;
					if (build_row == gce_pkg::MAX_ROWS) begin
						build_code = 8'($urandom_range(255));
						build_row = 0;
					end
				end else begin
					send_item(gce_pkg::REQ_LOAD, 8'($urandom_range(255)),
						5'($urandom_range(31)), $urandom, 12'($urandom_range(4095)),
						12'($urandom_range(4095)), $urandom);
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_random_traffic();
		settle();
		if (mismatches == 0) begin
			$display("glyph_color_expander_top verification clean");
		end else begin
			$display("glyph_color_expander_top verification failed");
		end
		$finish;
	end
endmodule

/* files.f */
hdl/gce_pkg.sv
hdl/gce_ram.sv
hdl/gce_cfg.sv
hdl/gce_seq.sv
hdl/glyph_color_expander_top.sv
verif/tb.sv
